### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/sbmg_pkg.sv
// ----------------------------------------------------------------------------
// sbmg_pkg
// Codes, constants, shared types and the sigmoid table of the gradient block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbmg_pkg;

  // input word function codes
  localparam logic [1:0] FUNC_SCORE   = 2'd0;
  localparam logic [1:0] FUNC_WEIGHT  = 2'd1;
  localparam logic [1:0] FUNC_EDGE    = 2'd2;
  localparam logic [1:0] FUNC_COMPUTE = 2'd3;

  // configuration register indexes
  localparam logic CFG_NODE_COUNT    = 1'b0;
  localparam logic CFG_CLUSTER_COUNT = 1'b1;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] W_ONE   = 16'd32768;

  // operands of the shared multiplier
  typedef struct packed {
    logic signed [31:0] op_a;
    logic signed [17:0] op_b;
  } mul_req_t;

  // sigmoid at steps of 0.5 from 0, Q1.16; saturates to one
  function automatic logic [16:0] sig_tbl(input logic [5:0] idx);
    logic [16:0] v;
    case (idx)
      6'd0:    v = 17'd32768;
      6'd1:    v = 17'd40793;
      6'd2:    v = 17'd47911;
      6'd3:    v = 17'd53581;
      6'd4:    v = 17'd57724;
      6'd5:    v = 17'd60565;
      6'd6:    v = 17'd62428;
      6'd7:    v = 17'd63615;
      6'd8:    v = 17'd64357;
      6'd9:    v = 17'd64816;
      6'd10:   v = 17'd65097;
      6'd11:   v = 17'd65269;
      6'd12:   v = 17'd65374;
      6'd13:   v = 17'd65438;
      6'd14:   v = 17'd65476;
      6'd15:   v = 17'd65500;
      6'd16:   v = 17'd65514;
      6'd17:   v = 17'd65523;
      6'd18:   v = 17'd65528;
      6'd19:   v = 17'd65531;
      6'd20:   v = 17'd65533;
      6'd21:   v = 17'd65534;
      6'd22:   v = 17'd65535;
      6'd23:   v = 17'd65535;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/sbmg_mul.sv
// ----------------------------------------------------------------------------
// sbmg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbmg_mul (
  input  logic                clk_i,
  input  sbmg_pkg::mul_req_t  req_i,
  output logic signed [49:0]  prod_o
);
  import sbmg_pkg::*;

  logic signed [49:0] prod_q;

  // product is registered and lands in the cycle after the operands
  always_ff @(posedge clk_i) begin
    prod_q <= 50'(req_i.op_a * req_i.op_b);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/block_model_score_gradient_unit.sv
// ----------------------------------------------------------------------------
// block_model_score_gradient_unit
// Block model logistic gradient: loads scores, weights and edges, then on a
// compute word walks all node pairs through one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | func, node_a/b, cluster, ...
//  out     | output    | out_valid_o/out_stall_i | cluster_out, gradient, last
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  Load words are taken while the sequencer is idle. A compute word steps
//  the term loop through the single multiplier for K clusters and all
//  P = N*(N-1)/2 node pairs. in_stall_o is high for the whole compute; a
//  stalled output word only holds the sequencer at the output step. Reset
//  clears control state and scores; weight and edge memories hold no
//  reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module block_model_score_gradient_unit #(
  parameter int MAX_NODES    = 256,
  parameter int MAX_CLUSTERS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [7:0]         node_a_i,
  input  logic [7:0]         node_b_i,
  input  logic [2:0]         cluster_i,
  input  logic signed [15:0] score_i,
  input  logic [15:0]        weight_i,
  input  logic               edge_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         cluster_out_o,
  output logic signed [36:0] gradient_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [8:0]         cfg_data_i
);
  import sbmg_pkg::*;

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int KCW = $clog2(MAX_CLUSTERS + 1);
  localparam int WAW = NW + CW;
  localparam int EAW = 2 * NW;
  localparam int PAW = 2 * CW;
  localparam int PD  = 2 ** PAW;

  localparam logic signed [52:0] GRAD_HI = 53'sd68719476735;
  localparam logic signed [52:0] GRAD_LO = -53'sd68719476736;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SIGA = 4'd1;
  localparam logic [3:0] S_SIGB = 4'd2;
  localparam logic [3:0] S_SIGC = 4'd3;
  localparam logic [3:0] S_SIGD = 4'd4;
  localparam logic [3:0] S_WI   = 4'd5;
  localparam logic [3:0] S_WIC  = 4'd6;
  localparam logic [3:0] S_WJ   = 4'd7;
  localparam logic [3:0] S_MUL1 = 4'd8;
  localparam logic [3:0] S_MUL2 = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_RA   = 4'd11;
  localparam logic [3:0] S_RB   = 4'd12;
  localparam logic [3:0] S_RC   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic               in_acc;
  logic               out_acc;

  logic [8:0]         node_count_q;
  logic [3:0]         cluster_count_q;
  logic [NCW-1:0]     n_eff;
  logic [KCW-1:0]     kc_eff;

  logic signed [15:0] score_q [MAX_CLUSTERS];
  logic signed [15:0] score_rd;
  logic [CW-1:0]      score_sel;

  logic [15:0]        weight_mem [2**WAW];
  logic [WAW-1:0]     w_raddr;
  logic [15:0]        w_rd_q;
  logic               edge_mem [2**EAW];
  logic               edge_rd_q;
  logic [16:0]        sig_mem [PD];
  logic [16:0]        sig_rd_q;
  logic               sig_we;
  logic [16:0]        sig_val;
  logic signed [47:0] acc_mem [PD];
  logic [PD-1:0]      acc_vld_q, acc_vld_d;
  logic [PAW-1:0]     acc_raddr;
  logic signed [47:0] acc_rd_q;
  logic               acc_rd_vld_q;
  logic signed [47:0] acc_rd_val;
  logic               acc_we;
  logic signed [47:0] acc_new;

  logic [3:0]         state_q, state_d;
  logic [CW-1:0]      k_q, k_d, l_q, l_d;
  logic [NW-1:0]      i_q, i_d, j_q, j_d;
  logic [NCW-1:0]     n_q, n_d;
  logic [KCW-1:0]     kc_q, kc_d;
  logic signed [15:0] sa_q, sa_d;
  logic signed [16:0] x_q, x_d;
  logic [15:0]        wi_q, wi_d;
  logic signed [17:0] d_q, d_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [52:0] v_q, v_d;

  logic               out_valid_q, out_valid_d;
  logic [2:0]         cluster_out_q, cluster_out_d;
  logic signed [36:0] gradient_q, gradient_d;
  logic               last_q, last_d;

  logic               l_last, k_last, j_more, i_more;

  logic               x_neg;
  logic [16:0]        x_abs;
  logic [5:0]         tbl_i;
  logic [10:0]        tbl_f;
  logic [16:0]        tbl_lo, tbl_hi, tbl_diff;
  logic signed [49:0] interp;
  logic [16:0]        sig_pos;

  logic signed [52:0] v_rnd, r_sh, r_sat;

  mul_req_t           mul_req;
  logic signed [49:0] mul_p;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q    <= 9'd2;
      cluster_count_q <= 4'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_NODE_COUNT) begin
        node_count_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_CLUSTER_COUNT) begin
        cluster_count_q <= cfg_data_i[3:0];
      end
    end
  end

  // clamp counts to what the stores hold
  assign n_eff  = (node_count_q > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_q);
  assign kc_eff = (cluster_count_q == 4'd0) ? KCW'(1) :
                  (cluster_count_q > MAX_CLUSTERS) ? KCW'(MAX_CLUSTERS) :
                  KCW'(cluster_count_q);

  // score registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        score_q[c] <= '0;
      end
    end else if (in_acc && func_i == FUNC_SCORE && cluster_i < MAX_CLUSTERS) begin
      score_q[CW'(cluster_i)] <= score_i;
    end
  end

  assign score_sel = (state_q == S_SIGA) ? k_q : l_q;
  assign score_rd  = score_q[score_sel];

  // weight memory, weights above one stored as one
  assign w_raddr = (state_q == S_WI) ? {i_q, k_q} : {j_q, l_q};

  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == FUNC_WEIGHT && cluster_i < MAX_CLUSTERS &&
        node_a_i < MAX_NODES) begin
      weight_mem[{NW'(node_a_i), CW'(cluster_i)}] <= (weight_i > W_ONE) ? W_ONE : weight_i;
    end
    w_rd_q <= weight_mem[w_raddr];
  end

  // edge memory, upper triangle only
  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == FUNC_EDGE && node_b_i > node_a_i && node_b_i < MAX_NODES) begin
      edge_mem[{NW'(node_a_i), NW'(node_b_i)}] <= edge_req_i;
    end
    edge_rd_q <= edge_mem[{i_q, j_q}];
  end

  // sigmoid per cluster pair
  always_ff @(posedge clk_i) begin
    if (sig_we) begin
      sig_mem[{k_q, l_q}] <= sig_val;
    end
    sig_rd_q <= sig_mem[{k_q, l_q}];
  end

  // pair accumulators; valid bits stand in for the clear
  assign acc_raddr  = (state_q == S_RB) ? {l_q, k_q} : {k_q, l_q};
  assign acc_rd_val = acc_rd_vld_q ? acc_rd_q : 48'sd0;
  assign acc_new    = acc_q + 48'(mul_p >>> 14);

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[{k_q, l_q}] <= acc_new;
    end
    acc_rd_q <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q    <= '0;
      acc_rd_vld_q <= 1'b0;
    end else begin
      acc_vld_q    <= acc_vld_d;
      acc_rd_vld_q <= acc_vld_q[acc_raddr];
    end
  end

  // sigmoid interpolation from the registered score sum
  assign x_neg    = x_q[16];
  assign x_abs    = x_neg ? (~x_q + 17'd1) : x_q;
  assign tbl_i    = x_abs[16:11];
  assign tbl_f    = x_abs[10:0];
  assign tbl_lo   = sig_tbl(tbl_i);
  assign tbl_hi   = sig_tbl(tbl_i + 6'd1);
  assign tbl_diff = tbl_hi - tbl_lo;
  assign interp   = (mul_p + 50'sd1024) >>> 11;
  assign sig_pos  = (tbl_i >= 6'd32) ? ONE_Q16 : (tbl_lo + 17'(interp));
  assign sig_val  = x_neg ? (ONE_Q16 - sig_pos) : sig_pos;

  // shared multiplier operand select
  always_comb begin
    mul_req.op_a = '0;
    mul_req.op_b = '0;
    case (state_q)
      S_SIGC: begin
        mul_req.op_a = signed'({15'd0, tbl_diff});
        mul_req.op_b = signed'({7'd0, tbl_f});
      end
      S_MUL1: begin
        mul_req.op_a = signed'({16'd0, wi_q});
        mul_req.op_b = signed'({2'd0, w_rd_q});
      end
      S_MUL2: begin
        mul_req.op_a = signed'(mul_p[31:0]);
        mul_req.op_b = d_q;
      end
      default: begin
        mul_req.op_a = '0;
        mul_req.op_b = '0;
      end
    endcase
  end

  sbmg_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  // loop bounds
  assign l_last = (KCW'(l_q) + KCW'(1)) == kc_q;
  assign k_last = (KCW'(k_q) + KCW'(1)) == kc_q;
  assign j_more = (NCW'(j_q) + NCW'(1)) < n_q;
  assign i_more = (NCW'(i_q) + NCW'(2)) < n_q;

  // rounding and saturation of one component
  assign v_rnd = v_q + 53'sd32768;
  assign r_sh  = v_rnd >>> 16;
  assign r_sat = (r_sh > GRAD_HI) ? GRAD_HI : (r_sh < GRAD_LO) ? GRAD_LO : r_sh;

  // sequencer
  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    l_d           = l_q;
    i_d           = i_q;
    j_d           = j_q;
    n_d           = n_q;
    kc_d          = kc_q;
    sa_d          = sa_q;
    x_d           = x_q;
    wi_d          = wi_q;
    d_d           = d_q;
    acc_d         = acc_q;
    v_d           = v_q;
    acc_vld_d     = acc_vld_q;
    sig_we        = 1'b0;
    acc_we        = 1'b0;
    out_valid_d   = out_acc ? 1'b0 : out_valid_q;
    cluster_out_d = cluster_out_q;
    gradient_d    = gradient_q;
    last_d        = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && func_i == FUNC_COMPUTE) begin
          k_d       = '0;
          l_d       = '0;
          n_d       = n_eff;
          kc_d      = kc_eff;
          acc_vld_d = '0;
          state_d   = S_SIGA;
        end
      end
      S_SIGA: begin
        sa_d    = score_rd;
        state_d = S_SIGB;
      end
      S_SIGB: begin
        x_d     = 17'(sa_q) + 17'(score_rd);
        state_d = S_SIGC;
      end
      S_SIGC: begin
        state_d = S_SIGD;
      end
      S_SIGD: begin
        sig_we = 1'b1;
        if (!l_last) begin
          l_d     = l_q + CW'(1);
          state_d = S_SIGA;
        end else if (!k_last) begin
          k_d     = k_q + CW'(1);
          l_d     = '0;
          state_d = S_SIGA;
        end else begin
          k_d     = '0;
          l_d     = '0;
          i_d     = '0;
          j_d     = NW'(1);
          v_d     = '0;
          state_d = (n_q >= NCW'(2)) ? S_WI : S_RA;
        end
      end
      S_WI: begin
        state_d = S_WIC;
      end
      S_WIC: begin
        wi_d    = w_rd_q;
        l_d     = '0;
        state_d = S_WJ;
      end
      S_WJ: begin
        state_d = S_MUL1;
      end
      S_MUL1: begin
        d_d     = (edge_rd_q ? 18'sd65536 : 18'sd0) - signed'({1'b0, sig_rd_q});
        acc_d   = acc_rd_val;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_we                 = 1'b1;
        acc_vld_d[{k_q, l_q}]  = 1'b1;
        if (!l_last) begin
          l_d     = l_q + CW'(1);
          state_d = S_WJ;
        end else if (!k_last) begin
          k_d     = k_q + CW'(1);
          state_d = S_WI;
        end else begin
          k_d = '0;
          l_d = '0;
          if (j_more) begin
            j_d     = j_q + NW'(1);
            state_d = S_WI;
          end else if (i_more) begin
            i_d     = i_q + NW'(1);
            j_d     = i_q + NW'(2);
            state_d = S_WI;
          end else begin
            v_d     = '0;
            state_d = S_RA;
          end
        end
      end
      S_RA: begin
        state_d = S_RB;
      end
      S_RB: begin
        v_d     = v_q + 53'(acc_rd_val);
        state_d = S_RC;
      end
      S_RC: begin
        v_d = v_q + 53'(acc_rd_val);
        if (!l_last) begin
          l_d     = l_q + CW'(1);
          state_d = S_RA;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          cluster_out_d = 3'(k_q);
          gradient_d    = 37'(r_sat);
          last_d        = k_last;
          if (k_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + CW'(1);
            l_d     = '0;
            v_d     = '0;
            state_d = S_RA;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      l_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      l_q         <= l_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      kc_q        <= kc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sa_q          <= sa_d;
    x_q           <= x_d;
    wi_q          <= wi_d;
    d_q           <= d_d;
    acc_q         <= acc_d;
    v_q           <= v_d;
    cluster_out_q <= cluster_out_d;
    gradient_q    <= gradient_d;
    last_q        <= last_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cluster_out_o = cluster_out_q;
  assign gradient_o    = gradient_q;
  assign last_o        = last_q;

  // checks
  `ASSERT_NXT(a_compute_starts, in_valid_i && !in_stall_o && func_i == FUNC_COMPUTE, state_q == S_SIGA)
  `ASSERT_IMP(a_acc_index, state_q == S_ACC, (KCW'(k_q) < kc_q) && (KCW'(l_q) < kc_q))
  `ASSERT_IMP(a_pair_order, state_q == S_WJ, j_q > i_q)

endmodule

`default_nettype wire
